/* design/crss_pkg.sv */
package crss_pkg;

	localparam int COORD_W = 24;
	localparam int COEF_W  = 28;
	localparam int ACC_W   = 29;
	localparam int IDX_W   = 6;
	localparam int SEG_W   = 7;
	localparam logic [SEG_W-1:0] SEG_RESET = 7'd8;

	localparam logic signed [ACC_W-1:0] COORD_MAX = ACC_W'(  (1 << (COORD_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] COORD_MIN = ACC_W'(-(1 << (COORD_W - 1)));

	typedef logic signed [COORD_W-1:0] coord_t;

	// polynomial coefficients of one coordinate, Horner order
	typedef struct packed {
		logic signed [COEF_W-1:0] cu;
		logic signed [COEF_W-1:0] sq;
		logic signed [COEF_W-1:0] lin;
		logic signed [COEF_W-1:0] b2;
	} coef_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             last;
	} ctl_t;

	function automatic coef_t crss_coefs(coord_t a, coord_t b, coord_t c, coord_t d);
		logic signed [COEF_W-1:0] ea;
		logic signed [COEF_W-1:0] eb;
		logic signed [COEF_W-1:0] ec;
		logic signed [COEF_W-1:0] ed;
		coef_t r;
		ea = COEF_W'(a);
		eb = COEF_W'(b);
		ec = COEF_W'(c);
		ed = COEF_W'(d);
		r.cu  = (eb <<< 1) + eb - (ec <<< 1) - ec + ed - ea;
		r.sq  = (ea <<< 1) - (eb <<< 2) - eb + (ec <<< 2) - ed;
		r.lin = ec - ea;
		r.b2  = eb <<< 1;
		return r;
	endfunction

	function automatic coord_t crss_sat(logic signed [ACC_W-1:0] v);
		coord_t r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* design/crss_seq.sv */
module crss_seq #(
	parameter int MAX_SEGMENTS = 64,
	parameter int T_FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [crss_pkg::SEG_W-1:0]      seg_cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  crss_pkg::coord_t                p0_x,
	input  crss_pkg::coord_t                p0_y,
	input  crss_pkg::coord_t                p1_x,
	input  crss_pkg::coord_t                p1_y,
	input  crss_pkg::coord_t                p2_x,
	input  crss_pkg::coord_t                p2_y,
	input  crss_pkg::coord_t                p3_x,
	input  crss_pkg::coord_t                p3_y,
	input  logic                            adv,
	output crss_pkg::coef_t                 coef_x,
	output crss_pkg::coef_t                 coef_y,
	output logic [T_FRAC_BITS-1:0]          t,
	output crss_pkg::ctl_t                  ctl
);
	import crss_pkg::*;

	localparam int SIDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// per-count step of t = floor(2^T / n) and its remainder
	logic [T_FRAC_BITS:0] q_tbl [MAX_SEGMENTS];
	logic [SEG_W-1:0]     r_tbl [MAX_SEGMENTS];

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_tbl
		localparam int unsigned QV = (1 << T_FRAC_BITS) / (g + 1);
		localparam int unsigned RV = (1 << T_FRAC_BITS) % (g + 1);
		assign q_tbl[g] = (T_FRAC_BITS + 1)'(QV);
		assign r_tbl[g] = SEG_W'(RV);
	end

	logic                   busy_q;
	logic [IDX_W-1:0]       j_q;
	logic [T_FRAC_BITS-1:0] t_q;
	logic [SEG_W-1:0]       rem_q;
	logic [SEG_W-1:0]       segs_q;
	logic [T_FRAC_BITS:0]   step_q;
	logic [SEG_W-1:0]       rstep_q;
	coef_t                  coef_x_q;
	coef_t                  coef_y_q;

	logic [SEG_W-1:0]       segs_eff;
	logic [SIDX_W-1:0]      segs_idx;
	logic                   last_now;
	logic                   accept;
	logic [SEG_W:0]         rem_sum;
	logic                   carry;
	logic [T_FRAC_BITS:0]   t_sum;

	always_comb begin
		if (seg_cfg == '0) begin
			segs_eff = SEG_W'(1);
		end else if (seg_cfg > SEG_W'(MAX_SEGMENTS)) begin
			segs_eff = SEG_W'(MAX_SEGMENTS);
		end else begin
			segs_eff = seg_cfg;
		end
	end

	assign segs_idx = SIDX_W'(segs_eff - SEG_W'(1));
	assign last_now = ({1'b0, j_q} == (segs_q - SEG_W'(1)));
	assign in_stall = busy_q && !(last_now && adv);
	assign accept   = in_valid && !in_stall;

	// remainder stays below the count, so one conditional subtract keeps it there
	assign rem_sum = {1'b0, rem_q} + {1'b0, rstep_q};
	assign carry   = rem_sum >= {1'b0, segs_q};
	assign t_sum   = {1'b0, t_q} + step_q + (T_FRAC_BITS + 1)'(carry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			j_q    <= '0;
			t_q    <= '0;
			rem_q  <= '0;
			segs_q <= SEG_W'(1);
		end else if (accept) begin
			busy_q <= 1'b1;
			j_q    <= '0;
			t_q    <= '0;
			rem_q  <= '0;
			segs_q <= segs_eff;
		end else if (busy_q && adv) begin
			if (last_now) begin
				busy_q <= 1'b0;
			end else begin
				j_q   <= j_q + IDX_W'(1);
				t_q   <= t_sum[T_FRAC_BITS-1:0];
				rem_q <= carry ? SEG_W'(rem_sum - {1'b0, segs_q}) : rem_sum[SEG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_q   <= q_tbl[segs_idx];
			rstep_q  <= r_tbl[segs_idx];
			coef_x_q <= crss_coefs(p0_x, p1_x, p2_x, p3_x);
			coef_y_q <= crss_coefs(p0_y, p1_y, p2_y, p3_y);
		end
	end

	assign coef_x    = coef_x_q;
	assign coef_y    = coef_y_q;
	assign t         = t_q;
	assign ctl.valid = busy_q;
	assign ctl.idx   = j_q;
	assign ctl.last  = last_now;

endmodule

/* design/crss_lane.sv */
module crss_lane #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   adv,
	input  crss_pkg::coef_t        coef,
	input  logic [T_FRAC_BITS-1:0] t,
	output crss_pkg::coord_t       res
);
	import crss_pkg::*;

	localparam int PROD_W = ACC_W + T_FRAC_BITS + 1;

	logic signed [T_FRAC_BITS:0] ts;
	assign ts = $signed({1'b0, t});

	logic signed [PROD_W-1:0]  m1_s1;
	logic signed [COEF_W-1:0]  sq_s1;
	logic signed [COEF_W-1:0]  lin_s1, lin_s2, lin_s3;
	logic signed [COEF_W-1:0]  b2_s1, b2_s2, b2_s3, b2_s4, b2_s5;
	logic [T_FRAC_BITS-1:0]    t_s1, t_s2, t_s3, t_s4;
	logic signed [ACC_W-1:0]   h1_s2;
	logic signed [PROD_W-1:0]  m2_s3;
	logic signed [ACC_W-1:0]   h2_s4;
	logic signed [PROD_W-1:0]  m3_s5;
	coord_t                    res_s6;

	logic signed [T_FRAC_BITS:0] t2s, t4s;
	logic signed [ACC_W-1:0]     h3;

	assign t2s = $signed({1'b0, t_s2});
	assign t4s = $signed({1'b0, t_s4});
	assign h3  = ACC_W'(m3_s5 >>> T_FRAC_BITS) + ACC_W'(b2_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1  <= coef.cu * ts;
			sq_s1  <= coef.sq;
			lin_s1 <= coef.lin;
			b2_s1  <= coef.b2;
			t_s1   <= t;

			h1_s2  <= ACC_W'(m1_s1 >>> T_FRAC_BITS) + ACC_W'(sq_s1);
			lin_s2 <= lin_s1;
			b2_s2  <= b2_s1;
			t_s2   <= t_s1;

			m2_s3  <= h1_s2 * t2s;
			lin_s3 <= lin_s2;
			b2_s3  <= b2_s2;
			t_s3   <= t_s2;

			h2_s4  <= ACC_W'(m2_s3 >>> T_FRAC_BITS) + ACC_W'(lin_s3);
			b2_s4  <= b2_s3;
			t_s4   <= t_s3;

			m3_s5  <= h2_s4 * t4s;
			b2_s5  <= b2_s4;

			// final halving floors, then clamp to the coordinate range
			res_s6 <= crss_sat(h3 >>> 1);
		end
	end

	assign res = res_s6;

endmodule

/* design/crss_merge.sv */
module crss_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  crss_pkg::ctl_t    ctl,
	input  crss_pkg::coord_t  res_x,
	input  crss_pkg::coord_t  res_y,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_stall,
	output crss_pkg::coord_t  out_x,
	output crss_pkg::coord_t  out_y,
	output logic [crss_pkg::IDX_W-1:0] sample_index,
	output logic              last_sample
);
	import crss_pkg::*;

	// control rides alongside the lane pipeline, six stages deep
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic             out_valid_q;
	coord_t           out_x_q;
	coord_t           out_y_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;

	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s1      <= ctl;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			ctl_s5      <= ctl_s4;
			ctl_s6      <= ctl_s5;
			out_valid_q <= ctl_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= res_x;
			out_y_q <= res_y;
			idx_q   <= ctl_s6.idx;
			last_q  <= ctl_s6.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign sample_index = idx_q;
	assign last_sample  = last_q;

endmodule

/* design/catmull_rom_segment_sampler_core.sv */
// Uniform Catmull-Rom segment sampler. Each input transaction carries four
// control points p0..p3 (signed Q16.8); the block then emits one output
// transaction per sample of the segment from p1 toward p2, at
// t_j = floor(j * 2^T_FRAC_BITS / n), where n is segments_per_curve clamped
// to 1..MAX_SEGMENTS. The sequencer issues one sample per cycle while the output
// is not stalled, so an input transaction yields n samples (8 at reset) and the next one is taken in the
// cycle its predecessor issues its last sample. The x and y lanes evaluate
// the cubic in Horner form in six stages, and each result then passes through
// the merge output register. Output stall freezes the whole sample pipeline.
// segments_per_curve should only be written while the block is idle.
module catmull_rom_segment_sampler_core #(
	parameter int MAX_SEGMENTS = 64,
	parameter int T_FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            segments_per_curve_we,
	input  logic [crss_pkg::SEG_W-1:0]      segments_per_curve,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  crss_pkg::coord_t                p0_x,
	input  crss_pkg::coord_t                p0_y,
	input  crss_pkg::coord_t                p1_x,
	input  crss_pkg::coord_t                p1_y,
	input  crss_pkg::coord_t                p2_x,
	input  crss_pkg::coord_t                p2_y,
	input  crss_pkg::coord_t                p3_x,
	input  crss_pkg::coord_t                p3_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output crss_pkg::coord_t                out_x,
	output crss_pkg::coord_t                out_y,
	output logic [crss_pkg::IDX_W-1:0]      sample_index,
	output logic                            last_sample
);
	import crss_pkg::*;

	logic [SEG_W-1:0]       seg_cfg_q;
	logic                   adv;
	coef_t                  coef_x;
	coef_t                  coef_y;
	logic [T_FRAC_BITS-1:0] t;
	ctl_t                   ctl;
	coord_t                 res_x;
	coord_t                 res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= SEG_RESET;
		end else if (segments_per_curve_we) begin
			seg_cfg_q <= segments_per_curve;
		end
	end

	crss_seq #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.T_FRAC_BITS  (T_FRAC_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_cfg  (seg_cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.p0_x     (p0_x),
		.p0_y     (p0_y),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.p3_x     (p3_x),
		.p3_y     (p3_y),
		.adv      (adv),
		.coef_x   (coef_x),
		.coef_y   (coef_y),
		.t        (t),
		.ctl      (ctl)
	);

	crss_lane #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_lane_x (
		.clk  (clk),
		.adv  (adv),
		.coef (coef_x),
		.t    (t),
		.res  (res_x)
	);

	crss_lane #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_lane_y (
		.clk  (clk),
		.adv  (adv),
		.coef (coef_y),
		.t    (t),
		.res  (res_y)
	);

	crss_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.res_x        (res_x),
		.res_y        (res_y),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.sample_index (sample_index),
		.last_sample  (last_sample)
	);

endmodule

/* verif/catmull_rom_segment_sampler_core_test.sv */
`timescale 1ns / 100ps

module catmull_rom_segment_sampler_core_test;
	import crss_pkg::*;

	localparam int MAX_SEGS      = 64;
	localparam int T_BITS        = 16;
	localparam int QUIET_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_MAX    = 10;

	localparam longint COORD_HI = 64'sd8388607;
	localparam longint COORD_LO = -64'sd8388608;
	localparam coord_t C_HI     = 24'sh7FFFFF;
	localparam coord_t C_LO     = 24'sh800000;

	typedef struct {
		coord_t px[4];
		coord_t py[4];
	} window_t;

	typedef struct packed {
		coord_t           x;
		coord_t           y;
		logic [IDX_W-1:0] idx;
		logic             last;
	} sample_t;

	class spline_scoreboard;
		logic [SEG_W-1:0] seg_reg;
		sample_t          sample_q[$];
		int               mismatches;
		int               samples_seen;

		function new();
			seg_reg = SEG_RESET;
			mismatches = 0;
			samples_seen = 0;
		endfunction

		function void set_segments(logic [SEG_W-1:0] v);
			seg_reg = v;
		endfunction

		function int pending();
			return sample_q.size();
		endfunction

		// register value clamped to 1..MAX_SEGS
		function int active_segments();
			int n;
			n = int'(seg_reg);
			if (n == 0) n = 1;
			if (n > MAX_SEGS) n = MAX_SEGS;
			return n;
		endfunction

		// Horner evaluation, every shift floors toward minus infinity
		function longint horner(longint a, longint b, longint c, longint d, longint t);
			longint lin;
			longint sq;
			longint cu;
			longint h;
			lin = c - a;
			sq  = 2 * a - 5 * b + 4 * c - d;
			cu  = -a + 3 * b - 3 * c + d;
			h = ((cu * t) >>> T_BITS) + sq;
			h = ((h * t) >>> T_BITS) + lin;
			h = ((h * t) >>> T_BITS) + 2 * b;
			return h >>> 1;
		endfunction

		function coord_t clamp_coord(longint v);
			if (v > COORD_HI) v = COORD_HI;
			if (v < COORD_LO) v = COORD_LO;
			return coord_t'(v);
		endfunction

		function void enqueue_sample(sample_t s);
			sample_q = {sample_q, s};
		endfunction

		function void note_window(window_t w);
			int n;
			longint t;
			sample_t s;
			n = active_segments();
			for (int j = 0; j < n; j++) begin
				t = (longint'(j) << T_BITS) / longint'(n);
				s.x    = clamp_coord(horner(longint'(w.px[0]), longint'(w.px[1]),
					longint'(w.px[2]), longint'(w.px[3]), t));
				s.y    = clamp_coord(horner(longint'(w.py[0]), longint'(w.py[1]),
					longint'(w.py[2]), longint'(w.py[3]), t));
				s.idx  = IDX_W'(j);
				s.last = (j == n - 1);
				enqueue_sample(s);
			end
		endfunction

		function void check_sample(sample_t got);
			sample_t want;
			if (sample_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: sample with nothing outstanding: x=%0d y=%0d idx=%0d last=%0b",
						$realtime, got.x, got.y, got.idx, got.last);
				return;
			end
			want = sample_q.pop_front();
			samples_seen++;
			if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: sample mismatch, expected x=%0d y=%0d idx=%0d last=%0b",
						$realtime, want.x, want.y, want.idx, want.last);
					$display("%0t:                  actual   x=%0d y=%0d idx=%0d last=%0b",
						$realtime, got.x, got.y, got.idx, got.last);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             seg_we;
	logic [SEG_W-1:0] seg_value;
	logic             in_valid;
	logic             in_stall;
	coord_t           p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	logic             out_valid;
	logic             out_stall;
	coord_t           out_x;
	coord_t           out_y;
	logic [IDX_W-1:0] sample_index;
	logic             last_sample;

	spline_scoreboard board;
	window_t          ring_win;
	int               in_calm;
	int               out_calm;
	int               quiet;
	int               windows_sent;
	int               settings_used;

	catmull_rom_segment_sampler_core dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.segments_per_curve_we (seg_we),
		.segments_per_curve    (seg_value),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.p0_x                  (p0_x),
		.p0_y                  (p0_y),
		.p1_x                  (p1_x),
		.p1_y                  (p1_y),
		.p2_x                  (p2_x),
		.p2_y                  (p2_y),
		.p3_x                  (p3_x),
		.p3_y                  (p3_y),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.out_x                 (out_x),
		.out_y                 (out_y),
		.sample_index          (sample_index),
		.last_sample           (last_sample)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random wait per transaction, with occasional runs of back-to-back traffic
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(4, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic coord_t pick_corner();
		case ($urandom_range(0, 5))
			0: return C_HI;
			1: return C_LO;
			2: return 24'sd0;
			3: return -24'sd1;
			4: return 24'sd1;
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic window_t make_window(coord_t x0, coord_t x1, coord_t x2, coord_t x3,
			coord_t y0, coord_t y1, coord_t y2, coord_t y3);
		window_t w;
		w.px = '{x0, x1, x2, x3};
		w.py = '{y0, y1, y2, y3};
		return w;
	endfunction

	// mostly a ring walk (window slides by one point), the rest noise, corners and small values
	function automatic window_t next_window(window_t prev);
		window_t w;
		int mode;
		int span;
		mode = $urandom_range(0, 19);
		span = ($urandom_range(0, 3) == 0) ? (1 << 20) : (1 << 13);
		if (mode < 11) begin
			for (int i = 0; i < 3; i++) begin
				w.px[i] = prev.px[i + 1];
				w.py[i] = prev.py[i + 1];
			end
			w.px[3] = prev.px[3] + coord_t'(int'($urandom_range(0, span)) - span / 2);
			w.py[3] = prev.py[3] + coord_t'(int'($urandom_range(0, span)) - span / 2);
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (mode < 16) begin
					w.px[i] = coord_t'($urandom());
					w.py[i] = coord_t'($urandom());
				end else if (mode < 19) begin
					w.px[i] = pick_corner();
					w.py[i] = pick_corner();
				end else begin
					w.px[i] = coord_t'(int'($urandom_range(0, 2048)) - 1024);
					w.py[i] = coord_t'(int'($urandom_range(0, 2048)) - 1024);
				end
			end
		end
		return w;
	endfunction

	task automatic send_window(window_t w);
		int gap;
		gap = draw_wait(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		p0_x <= w.px[0];
		p0_y <= w.py[0];
		p1_x <= w.px[1];
		p1_y <= w.py[1];
		p2_x <= w.px[2];
		p2_y <= w.py[2];
		p3_x <= w.px[3];
		p3_y <= w.py[3];
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_window(w);
		windows_sent++;
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [SEG_W-1:0] setting, int count);
		wait_drained();
		seg_we    <= 1'b1;
		seg_value <= setting;
		@(posedge clk);
		seg_we <= 1'b0;
		board.set_segments(setting);
		settings_used++;
		repeat (count) begin
			ring_win = next_window(ring_win);
			send_window(ring_win);
		end
		in_valid <= 1'b0;
	endtask

	task automatic run_directed();
		window_t w;
		send_window(make_window(0, 0, 0, 0, 0, 0, 0, 0));
		send_window(make_window(C_HI, C_HI, C_HI, C_HI, C_LO, C_LO, C_LO, C_LO));
		send_window(make_window(C_LO, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, C_HI));
		// zigzags drive the cubic past the coordinate range
		send_window(make_window(C_HI, C_LO, C_HI, C_LO, C_LO, C_HI, C_LO, C_HI));
		send_window(make_window(C_LO, C_HI, C_LO, C_HI, C_HI, C_LO, C_HI, C_LO));
		send_window(make_window(C_LO, C_HI, C_HI, C_LO, C_HI, C_LO, C_LO, C_HI));
		send_window(make_window(0, C_HI, C_LO, 0, 0, C_LO, C_HI, 0));
		send_window(make_window(C_HI, C_HI, C_LO, C_LO, C_LO, C_LO, C_HI, C_HI));
		send_window(make_window(-1, -1, -1, -1, 1, 1, 1, 1));
		send_window(make_window(1, -1, 1, -1, -1, 1, -1, 1));
		send_window(make_window(0, 256, 512, 768, 0, -256, -512, -768));
		send_window(make_window(1000, 5000, 5000, 9000, -7, 3, 3, -7));
		send_window(make_window(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
			24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555));
		send_window(make_window(C_HI, 0, 0, C_LO, C_LO, 0, 0, C_HI));
		repeat (6) begin
			w = make_window(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
				pick_corner(), pick_corner(), pick_corner(), pick_corner());
			send_window(w);
		end
		ring_win = w;
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
				$display("catmull_rom_segment_sampler_core_test: errors");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		sample_t got;
		int stall_n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall_n = draw_wait(out_calm);
			if (stall_n > 0) begin
				out_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = '{out_x, out_y, sample_index, last_sample};
			board.check_sample(got);
		end
	end

	initial begin
		board = new();
		in_calm = 0;
		out_calm = 0;
		quiet = 0;
		windows_sent = 0;
		settings_used = 1;
		arst_n    <= 1'b0;
		seg_we    <= 1'b0;
		seg_value <= SEG_RESET;
		in_valid  <= 1'b0;
		p0_x <= '0;
		p0_y <= '0;
		p1_x <= '0;
		p1_y <= '0;
		p2_x <= '0;
		p2_y <= '0;
		p3_x <= '0;
		p3_y <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the segment count first, then small, zero and oversized counts
		run_directed();
		run_phase(7'd1, 50);
		run_phase(7'd0, 30);
		run_phase(7'd64, 6);
		run_phase(7'd2, 40);
		run_phase(7'd127, 4);
		run_phase(7'd3, 40);
		run_phase(7'd65, 4);
		run_phase(7'd5, 40);
		run_phase(7'd16, 20);
		run_phase(7'd63, 5);
		run_phase(7'd8, 60);
		run_phase(7'd13, 25);
		run_phase(7'd4, 40);
		run_phase(SEG_W'($urandom_range(1, 12)), 30);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d control-point windows under %0d segment-count settings",
			windows_sent, settings_used);
		$display("%0d samples compared, %0d mismatches, %0d still outstanding",
			board.samples_seen, board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("catmull_rom_segment_sampler_core_test: clean");
		end else begin
			$display("catmull_rom_segment_sampler_core_test: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/crss_pkg.sv
design/crss_seq.sv
design/crss_lane.sv
design/crss_merge.sv
design/catmull_rom_segment_sampler_core.sv
verif/catmull_rom_segment_sampler_core_test.sv
